// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Entry and carry records, cell operation codes, status and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int MAX_BLOCKS_D     = 64;
	localparam int HEADER_BYTES_D   = 20;
	localparam int MIN_DATA_BYTES_D = 30;

	localparam logic [20:0] LIMIT_CAP     = 21'd1048576;
	localparam logic [20:0] LIMIT_RESET   = 21'd65536;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_RESET   = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_FREED   = 3'd5;

	typedef enum logic [2:0] {
		C_NOP, C_LATCH, C_SPLIT, C_TAKE, C_APPEND, C_MARK, C_MERGE_R, C_MERGE_L
	} cell_op_t;

	typedef struct packed {
		logic [19:0] off;
		logic [19:0] cap;
		logic        free;
	} entry_t;

	// first hit travelling down the chain, with its neighbors' free flags
	typedef struct packed {
		logic        found;
		logic [19:0] off;
		logic [19:0] cap;
		logic        free;
		logic        lfree;
		logic        rfree;
	} carry_t;

	typedef struct packed {
		cell_op_t    op;
		logic        is_alloc;
		logic [20:0] rcap;
		logic [19:0] addr;
		logic [19:0] ins_off;
		logic [19:0] ins_cap;
		logic [19:0] top_off;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ffha_cell.sv -----
// ----------------------------------------------------------------------------
// ffha_cell: one table entry of the allocator
// Holds one block record, forwards the first hit to its right neighbor and
// shifts records to or from its neighbors on insert and merge.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_cell import ffha_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int HDR = HEADER_BYTES_D
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [CW-1:0] count,
	input  wire entry_t        left_ent,
	input  wire logic          left_first,
	input  wire entry_t        right_ent,
	input  wire logic          right_first,
	input  wire carry_t        carry_in,
	output entry_t             ent,
	output logic               first,
	output carry_t             carry_out
);

	localparam logic [CW:0] IDX_W = (CW+1)'(IDX);
	localparam logic [CW:0] NXT_W = (CW+1)'(IDX + 1);

	entry_t ent_q;
	logic   first_q, after_q;
	carry_t carry_q;
	logic   in_rng, r_rng, is_tail, match;
	carry_t carry_d;

	assign in_rng  = {1'b0, count} > IDX_W;
	assign r_rng   = {1'b0, count} > NXT_W;
	assign is_tail = {1'b0, count} == IDX_W;

	always_comb begin
		if (ctl.is_alloc) begin
			match = in_rng && ent_q.free && ({1'b0, ent_q.cap} >= ctl.rcap);
		end else begin
			match = in_rng && ((21'(ent_q.off) + 21'(HDR)) == {1'b0, ctl.addr});
		end
	end

	always_comb begin
		if (carry_in.found) begin
			carry_d = carry_in;
		end else begin
			carry_d.found = match;
			carry_d.off   = ent_q.off;
			carry_d.cap   = ent_q.cap;
			carry_d.free  = ent_q.free;
			carry_d.lfree = left_ent.free;
			carry_d.rfree = r_rng && right_ent.free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			first_q <= 1'b0;
			after_q <= 1'b0;
		end else begin
			carry_q <= carry_d;
			if (ctl.op == C_LATCH) begin
				first_q <= match && !carry_in.found;
				after_q <= carry_in.found;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			C_SPLIT: begin
				if (first_q) begin
					ent_q.cap  <= ctl.rcap[19:0];
					ent_q.free <= 1'b0;
				end else if (left_first) begin
					ent_q <= '{off: ctl.ins_off, cap: ctl.ins_cap, free: 1'b1};
				end else if (after_q) begin
					ent_q <= left_ent;
				end
			end
			C_TAKE: begin
				if (first_q) ent_q.free <= 1'b0;
			end
			C_APPEND: begin
				if (is_tail) ent_q <= '{off: ctl.top_off, cap: ctl.rcap[19:0], free: 1'b0};
			end
			C_MARK: begin
				if (first_q) ent_q.free <= 1'b1;
			end
			C_MERGE_R: begin
				if (first_q) begin
					ent_q.cap  <= ent_q.cap + 20'(HDR) + right_ent.cap;
					ent_q.free <= 1'b1;
				end else if (after_q) begin
					ent_q <= right_ent;
				end
			end
			C_MERGE_L: begin
				// absorb the released block from the right, close the gap
				if (right_first) begin
					ent_q.cap <= ent_q.cap + 20'(HDR) + right_ent.cap;
				end else if (first_q || after_q) begin
					ent_q <= right_ent;
				end
			end
			default: ;
		endcase
	end

	assign ent       = ent_q;
	assign first     = first_q;
	assign carry_out = carry_q;

endmodule

`default_nettype wire

// ----- rtl/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator
// Address-ordered block table held in a chain of cells, one block per cell.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid, in_stall) carries action,
// request_size and release_address; each gives exactly one output
// transaction (out_valid, out_stall) with data_address and status.
// heap_limit is written through cfg_valid / cfg_ready (always ready); the user
// must do so only while the block is idle, which the block does not enforce.
// Allocate (nonzero size) and release pass through S_SCAN, S_LATCH and
// S_EXEC before out_valid rises; a release that merges with its left
// neighbor also passes S_MERGE. Heap reset, zero size and the unused action
// go straight to S_DONE. The scan lets the hit search ripple one cell per
// cycle down the whole chain. One item is in flight at a time; the next is
// accepted once the result sits in the output register, even while
// out_stall holds it. Reset empties the heap and sets heap_limit to 65536.
// A stalled result holds in the output register; a finished item waits for
// it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int MAX_BLOCKS     = MAX_BLOCKS_D,
	parameter int HEADER_BYTES   = HEADER_BYTES_D,
	parameter int MIN_DATA_BYTES = MIN_DATA_BYTES_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [20:0] heap_limit,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [20:0] request_size,
	input  wire logic [19:0] release_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [19:0]      data_address,
	output logic [2:0]       status
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = $clog2(MAX_BLOCKS);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
	localparam logic [SW-1:0] SCAN_LAST = SW'(MAX_BLOCKS - 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LATCH, S_EXEC, S_MERGE, S_DONE} state_t;

	state_t      state_q;
	logic [SW-1:0] scan_q;
	logic [CW-1:0] cnt_q;
	logic [20:0] top_q, limit_q, rcap_q;
	logic        alloc_q, lmerge_q;
	logic [19:0] addr_q, ins_off_q, ins_cap_q;
	cell_op_t    op_q;
	logic [19:0] res_addr_q;
	logic [2:0]  res_st_q;
	logic        out_valid_q;
	logic [19:0] out_addr_q;
	logic [2:0]  out_st_q;

	cell_ctl_t ctl;
	entry_t    ents [MAX_BLOCKS];
	logic      firsts [MAX_BLOCKS];
	carry_t    cars [MAX_BLOCKS];
	carry_t    c_end;

	logic [20:0] lim;
	logic [21:0] grow_end, split_need;
	logic        split_ok;

	always_comb begin
		ctl.op = C_NOP;
		case (state_q)
			S_LATCH: ctl.op = C_LATCH;
			S_EXEC:  ctl.op = op_q;
			S_MERGE: ctl.op = C_MERGE_L;
			default: ctl.op = C_NOP;
		endcase
		ctl.is_alloc = alloc_q;
		ctl.rcap     = rcap_q;
		ctl.addr     = addr_q;
		ctl.ins_off  = ins_off_q;
		ctl.ins_cap  = ins_cap_q;
		ctl.top_off  = top_q[19:0];
	end

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		entry_t l_ent, r_ent;
		logic   l_first, r_first;
		carry_t c_in;
		if (g == 0) begin : g_l0
			assign l_ent = '0;
			assign l_first = 1'b0;
			assign c_in = '0;
		end else begin : g_ln
			assign l_ent = ents[g-1];
			assign l_first = firsts[g-1];
			assign c_in = cars[g-1];
		end
		if (g == MAX_BLOCKS - 1) begin : g_r0
			assign r_ent = '0;
			assign r_first = 1'b0;
		end else begin : g_rn
			assign r_ent = ents[g+1];
			assign r_first = firsts[g+1];
		end
		ffha_cell #(.IDX(g), .CW(CW), .HDR(HEADER_BYTES)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .count(cnt_q),
			.left_ent(l_ent), .left_first(l_first),
			.right_ent(r_ent), .right_first(r_first),
			.carry_in(c_in), .ent(ents[g]), .first(firsts[g]), .carry_out(cars[g])
		);
	end

	assign c_end      = cars[MAX_BLOCKS-1];
	assign lim        = (limit_q > LIMIT_CAP) ? LIMIT_CAP : limit_q;
	assign grow_end   = {1'b0, top_q} + 22'(HEADER_BYTES) + {1'b0, rcap_q};
	assign split_need = {1'b0, rcap_q} + 22'(HEADER_BYTES) + 22'(MIN_DATA_BYTES);
	assign split_ok   = ({2'b0, c_end.cap} >= split_need) && (cnt_q != CNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= heap_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			cnt_q       <= '0;
			top_q       <= '0;
			alloc_q     <= 1'b0;
			lmerge_q    <= 1'b0;
			op_q        <= C_NOP;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result only once the output register is free
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						alloc_q    <= (action == ACT_ALLOC);
						addr_q     <= release_address;
						rcap_q     <= (request_size < 21'(MIN_DATA_BYTES)) ?
						              21'(MIN_DATA_BYTES) : request_size;
						res_addr_q <= '0;
						res_st_q   <= ST_OK;
						scan_q     <= '0;
						lmerge_q   <= 1'b0;
						op_q       <= C_NOP;
						state_q    <= S_DONE;
						case (action)
							ACT_ALLOC: begin
								if (request_size == '0) res_st_q <= ST_ZERO;
								else state_q <= S_SCAN;
							end
							ACT_RELEASE: state_q <= S_SCAN;
							ACT_RESET: begin
								cnt_q <= '0;
								top_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + SW'(1);
					if (scan_q == SCAN_LAST) state_q <= S_LATCH;
				end
				S_LATCH: begin
					state_q <= S_EXEC;
					if (alloc_q) begin
						if (c_end.found) begin
							op_q       <= split_ok ? C_SPLIT : C_TAKE;
							ins_off_q  <= c_end.off + 20'(HEADER_BYTES) + rcap_q[19:0];
							ins_cap_q  <= c_end.cap - rcap_q[19:0] - 20'(HEADER_BYTES);
							res_addr_q <= c_end.off + 20'(HEADER_BYTES);
						end else if (grow_end > {1'b0, lim}) begin
							res_st_q <= ST_NOSPACE;
						end else if (cnt_q == CNT_MAX) begin
							res_st_q <= ST_FULL;
						end else begin
							op_q       <= C_APPEND;
							res_addr_q <= 20'(top_q + 21'(HEADER_BYTES));
						end
					end else begin
						if (!c_end.found) begin
							res_st_q <= ST_UNKNOWN;
						end else if (c_end.free) begin
							res_st_q <= ST_FREED;
						end else begin
							op_q     <= c_end.rfree ? C_MERGE_R : C_MARK;
							lmerge_q <= c_end.lfree;
						end
					end
				end
				S_EXEC: begin
					state_q <= lmerge_q ? S_MERGE : S_DONE;
					case (op_q)
						C_SPLIT:   cnt_q <= cnt_q + CW'(1);
						C_APPEND: begin
							cnt_q <= cnt_q + CW'(1);
							top_q <= grow_end[20:0];
						end
						C_MERGE_R: cnt_q <= cnt_q - CW'(1);
						default: ;
					endcase
				end
				S_MERGE: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_addr_q  <= res_addr_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign data_address = out_addr_q;
	assign status       = out_st_q;

endmodule

`default_nettype wire

// ----- rtl/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks for the heap allocator
// Watches the top level's channels and flags illegal result behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker import ffha_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [19:0] data_address,
	input wire logic [2:0]  status
);

	// one transaction in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second transaction back to back");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_address) && $stable(status))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_FREED))
		else $error("undefined status code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (data_address == 20'd0))
		else $error("failed request returned an address");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.data_address(data_address), .status(status)
);

`default_nettype wire
